>>> rtl/qcts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QOI chunk tag statistics - shared definitions
// Parser phases, tag codes, header layout and the packed result width.
// ----------------------------------------------------------------------------
package qcts_pkg;

	// Parser phase, one-hot.
	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_HEADER  = 5'b00010,
		PH_TAG     = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_DONE    = 5'b10000
	} phase_t;

	// Tag codes and masks.
	localparam logic [7:0] TAG_RGB   = 8'hFE;
	localparam logic [7:0] TAG_RGBA  = 8'hFF;
	localparam logic [1:0] TOP_INDEX = 2'b00;
	localparam logic [1:0] TOP_DIFF  = 2'b01;
	localparam logic [1:0] TOP_LUMA  = 2'b10;

	// Payload byte counts per tag kind.
	localparam logic [2:0] PAYLOAD_RGB  = 3'd3;
	localparam logic [2:0] PAYLOAD_RGBA = 3'd4;
	localparam logic [2:0] PAYLOAD_LUMA = 3'd1;

	// Header byte positions.
	localparam logic [3:0] HDR_WIDTH_FIRST  = 4'd4;
	localparam logic [3:0] HDR_HEIGHT_FIRST = 4'd8;
	localparam logic [3:0] HDR_PRODUCT      = 4'd12;
	localparam logic [3:0] HDR_LAST         = 4'd13;

	// Result packing: magic_error plus eight 32-bit counters, padded to bytes.
	localparam int CNT_W       = 32;
	localparam int RESULT_BITS = 1 + 8 * CNT_W;
	localparam int M_TDATA_W   = ((RESULT_BITS + 7) / 8) * 8;
	localparam int PAD_W       = M_TDATA_W - RESULT_BITS;

	// Expected magic "qoif", one byte per header position.
	function automatic logic [7:0] magic_byte(input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0:    b = 8'h71;
			2'd1:    b = 8'h6F;
			2'd2:    b = 8'h69;
			default: b = 8'h66;
		endcase
		return b;
	endfunction

endpackage

>>> rtl/qoi_chunk_tag_statistics_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// QOI chunk tag statistics core
// Parses a QOI byte stream, checks the header magic and counts chunk tags by kind.
// ----------------------------------------------------------------------------
//  channel  dir  signals                      content
//  s_axis   in   tvalid tready tdata tuser    tdata: data_byte[7:0]; tuser: new_file
//  m_axis   out  tvalid tready tdata tlast    tlast: file_done; tdata: magic_error[0],
//                                             total[32:1] rgb[64:33] rgba[96:65]
//                                             index[128:97] diff[160:129] luma[192:161]
//                                             run[224:193] run_pixels[256:225]
//
//  One item per clock if not stalled; each byte's result is ready on the next cycle.
//  The result register is the statistics state itself, so a byte is taken
//  whenever the result slot is empty or is being drained in the same cycle.
//  The pixel count multiplier is registered one header byte before it is used.
//  Reset clears all counters and control, not dimensions; no start-up pass is needed.
// ----------------------------------------------------------------------------
module qoi_chunk_tag_statistics_core
	import qcts_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
	input  logic                 s_axis_tuser,   // [0] new_file
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata,   // magic_error, total, rgb, rgba, index,
	                                             // diff, luma, run, run_pixels, zero pad
	output logic                 m_axis_tlast    // file_done
);

	// Parser state
	phase_t           phase_q, phase_d;
	logic [3:0]       hdr_pos_q, hdr_pos_d;
	logic [31:0]      width_q, width_d;
	logic [31:0]      height_q, height_d;
	logic [31:0]      product_q;
	logic             product_en;
	logic [31:0]      pixels_left_q, pixels_left_d;
	logic [2:0]       payload_left_q, payload_left_d;
	logic             bad_magic_q, bad_magic_d;

	// Statistics, also the result register
	logic [CNT_W-1:0] total_q, rgb_q, rgba_q, index_q, diff_q, luma_q, run_q, run_pix_q;
	logic             inc_rgb, inc_rgba, inc_index, inc_diff, inc_luma, inc_run;
	logic             file_done_q, file_done_d;
	logic             out_valid_q;

	// Working signals
	logic             accept;
	phase_t           phase_eff;
	logic [3:0]       pos_eff;
	logic [7:0]       b;
	logic [6:0]       used;
	logic [2:0]       payload;
	logic             is_tag;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign b             = s_axis_tdata;

	// A new file restarts the header at this byte.
	assign phase_eff = s_axis_tuser ? PH_HEADER : phase_q;
	assign pos_eff   = s_axis_tuser ? 4'd0 : hdr_pos_q;

	// Tag classification.
	always_comb begin
		inc_rgb   = 1'b0;
		inc_rgba  = 1'b0;
		inc_index = 1'b0;
		inc_diff  = 1'b0;
		inc_luma  = 1'b0;
		inc_run   = 1'b0;
		used      = 7'd1;
		payload   = 3'd0;
		if (b == TAG_RGB) begin
			inc_rgb = 1'b1;
			payload = PAYLOAD_RGB;
		end else if (b == TAG_RGBA) begin
			inc_rgba = 1'b1;
			payload  = PAYLOAD_RGBA;
		end else if (b[7:6] == TOP_INDEX) begin
			inc_index = 1'b1;
		end else if (b[7:6] == TOP_DIFF) begin
			inc_diff = 1'b1;
		end else if (b[7:6] == TOP_LUMA) begin
			inc_luma = 1'b1;
			payload  = PAYLOAD_LUMA;
		end else begin
			inc_run = 1'b1;
			used    = {1'b0, b[5:0]} + 7'd1;
		end
	end

	// Next parser state for one byte.
	always_comb begin
		phase_d        = phase_q;
		hdr_pos_d      = hdr_pos_q;
		width_d        = width_q;
		height_d       = height_q;
		pixels_left_d  = pixels_left_q;
		payload_left_d = payload_left_q;
		bad_magic_d    = s_axis_tuser ? 1'b0 : bad_magic_q;
		file_done_d    = 1'b0;
		product_en     = 1'b0;
		is_tag         = 1'b0;
		case (phase_eff)
			PH_HEADER: begin
				payload_left_d = 3'd0;
				hdr_pos_d      = pos_eff + 4'd1;
				phase_d        = PH_HEADER;
				if (pos_eff < HDR_WIDTH_FIRST) begin
					if (b != magic_byte(pos_eff[1:0])) begin
						bad_magic_d = 1'b1;
						phase_d     = PH_DONE;
						hdr_pos_d   = pos_eff;
					end
				end else if (pos_eff < HDR_HEIGHT_FIRST) begin
					width_d = {width_q[23:0], b};
				end else if (pos_eff < HDR_PRODUCT) begin
					height_d = {height_q[23:0], b};
				end else if (pos_eff == HDR_PRODUCT) begin
					product_en = 1'b1;
				end else begin
					hdr_pos_d     = 4'd0;
					pixels_left_d = product_q;
					if (product_q == 32'd0) begin
						phase_d     = PH_DONE;
						file_done_d = 1'b1;
					end else begin
						phase_d = PH_TAG;
					end
				end
			end
			PH_TAG: begin
				is_tag = 1'b1;
				if ({25'd0, used} >= pixels_left_q) begin
					pixels_left_d  = 32'd0;
					payload_left_d = 3'd0;
					phase_d        = PH_DONE;
					file_done_d    = 1'b1;
				end else begin
					pixels_left_d  = pixels_left_q - {25'd0, used};
					payload_left_d = payload;
					phase_d        = (payload != 3'd0) ? PH_PAYLOAD : PH_TAG;
				end
			end
			PH_PAYLOAD: begin
				if (payload_left_q > 3'd1) begin
					payload_left_d = payload_left_q - 3'd1;
				end else begin
					payload_left_d = 3'd0;
					phase_d        = PH_TAG;
				end
			end
			default: begin
			end
		endcase
	end

	// Control and statistics registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			hdr_pos_q      <= 4'd0;
			pixels_left_q  <= 32'd0;
			payload_left_q <= 3'd0;
			bad_magic_q    <= 1'b0;
			file_done_q    <= 1'b0;
			out_valid_q    <= 1'b0;
			total_q        <= '0;
			rgb_q          <= '0;
			rgba_q         <= '0;
			index_q        <= '0;
			diff_q         <= '0;
			luma_q         <= '0;
			run_q          <= '0;
			run_pix_q      <= '0;
		end else begin
			if (accept) begin
				out_valid_q    <= 1'b1;
				phase_q        <= phase_d;
				hdr_pos_q      <= hdr_pos_d;
				pixels_left_q  <= pixels_left_d;
				payload_left_q <= payload_left_d;
				bad_magic_q    <= bad_magic_d;
				file_done_q    <= file_done_d;
				if (is_tag) begin
					total_q   <= total_q + 32'd1;
					rgb_q     <= rgb_q + {31'd0, inc_rgb};
					rgba_q    <= rgba_q + {31'd0, inc_rgba};
					index_q   <= index_q + {31'd0, inc_index};
					diff_q    <= diff_q + {31'd0, inc_diff};
					luma_q    <= luma_q + {31'd0, inc_luma};
					run_q     <= run_q + {31'd0, inc_run};
					run_pix_q <= run_pix_q + (inc_run ? {25'd0, used} : 32'd0);
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Header dimensions and the registered pixel product.
	always_ff @(posedge clk) begin
		if (accept) begin
			width_q  <= width_d;
			height_q <= height_d;
			if (product_en) begin
				product_q <= width_q * height_q;
			end
		end
	end

	// Result port.
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = file_done_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, run_pix_q, run_q, luma_q, diff_q, index_q,
	                        rgba_q, rgb_q, total_q, bad_magic_q};

`ifndef SYNTHESIS
	// A finished file leaves the parser waiting for the next file.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> (phase_q == PH_DONE))
		else $error("file_done without the parser in its done phase");

	// A bad magic always stops the parser for the rest of the file.
	assert property (@(posedge clk) disable iff (!arst_n)
		bad_magic_q |-> (phase_q == PH_DONE))
		else $error("magic error while the parser still runs");

	// The payload phase always has bytes left to skip.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (payload_left_q != 3'd0))
		else $error("payload phase with no payload bytes left");

	// One item adds at most one tag to the total.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ((total_q == $past(total_q)) || (total_q == $past(total_q) + 32'd1)))
		else $error("total tag count moved by more than one");
`endif

endmodule
